// ----- hw/rtl/swmf_pkg.sv -----
// Shared types and constants of the sliding window median filter.
package swmf_pkg;

    localparam int PIX_W = 8;
    localparam int CHANNELS = 3;
    localparam int WORD_W = PIX_W * CHANNELS;
    localparam int ROW_W = 12;
    localparam int COL_W = 11;
    localparam int CFG_W = 12;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd2;

    localparam logic [CFG_W-1:0] RESET_WIDTH = 12'd640;
    localparam logic [CFG_W-1:0] RESET_HEIGHT = 12'd480;
    localparam logic [1:0] RESET_CHANNELS = 2'd3;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] column;
        logic             done;
    } meta_t;

endpackage

// ----- hw/rtl/swmf_ram.sv -----
// Generic single-port RAM with read-first registered read.
module swmf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            rdata_reg <= mem[addr];
            if (we) begin
                mem[addr] <= wdata;
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/swmf_lane.sv -----
// One channel lane: pipelined odd-even transposition sort of the window.
module swmf_lane #(
    parameter int TAPS = 9
) (
    input  logic                      aclk,
    input  logic [TAPS-1:0]           stage_en,
    input  logic [swmf_pkg::PIX_W-1:0] win [TAPS],
    output logic [swmf_pkg::PIX_W-1:0] median
);
    import swmf_pkg::*;

    localparam int MID = TAPS / 2;

    logic [PIX_W-1:0] stg_reg [TAPS][TAPS];

    for (genvar s = 0; s < TAPS; s++) begin : g_stage
        logic [PIX_W-1:0] src [TAPS];
        logic [PIX_W-1:0] srt [TAPS];

        if (s == 0) begin : g_first
            always_comb begin
                for (int i = 0; i < TAPS; i++) src[i] = win[i];
            end
        end else begin : g_rest
            always_comb begin
                for (int i = 0; i < TAPS; i++) src[i] = stg_reg[s-1][i];
            end
        end

        always_comb begin
            for (int i = 0; i < TAPS; i++) srt[i] = src[i];
            for (int i = s % 2; i + 1 < TAPS; i += 2) begin
                if (src[i] > src[i+1]) begin
                    srt[i] = src[i+1];
                    srt[i+1] = src[i];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (stage_en[s]) begin
                for (int i = 0; i < TAPS; i++) stg_reg[s][i] <= srt[i];
            end
        end
    end

    assign median = stg_reg[TAPS-1][MID];

endmodule

// ----- hw/rtl/swmf_merge.sv -----
// Merge stage: mask unused channels and register the result word.
module swmf_merge (
    input  logic                       aclk,
    input  logic                       load,
    input  logic [1:0]                 channel_count,
    input  swmf_pkg::meta_t            meta,
    input  logic [swmf_pkg::PIX_W-1:0] lane_median [swmf_pkg::CHANNELS],
    output logic [swmf_pkg::ROW_W-1:0] out_row,
    output logic [swmf_pkg::COL_W-1:0] out_column,
    output logic [swmf_pkg::PIX_W-1:0] median_ch0,
    output logic [swmf_pkg::PIX_W-1:0] median_ch1,
    output logic [swmf_pkg::PIX_W-1:0] median_ch2,
    output logic                       frame_done
);
    import swmf_pkg::*;

    meta_t            meta_reg;
    logic [PIX_W-1:0] med_reg [CHANNELS];

    always_ff @(posedge aclk) begin
        if (load) begin
            meta_reg <= meta;
            for (int ch = 0; ch < CHANNELS; ch++) begin
                med_reg[ch] <= (ch < int'(channel_count)) ? lane_median[ch] : '0;
            end
        end
    end

    assign out_row = meta_reg.row;
    assign out_column = meta_reg.column;
    assign frame_done = meta_reg.done;
    assign median_ch0 = med_reg[0];
    assign median_ch1 = med_reg[1];
    assign median_ch2 = med_reg[2];

endmodule

// ----- hw/rtl/sliding_window_median_filter.sv -----
// Top level of the sliding window median filter.
// Input to result: stage 1, window register, sort stages, merge register.
// Throughput: one word per cycle, set by the one-pass sorting pipeline per lane,
// while the output is not stalled; stalls propagate back combinationally; bubbles are squeezed out.
// Reset: synchronous active low; counters, window and valids clear, registers
// return to 640 x 480, 3 channels; line buffers are not cleared.
module sliding_window_median_filter #(
    parameter int WINDOW_RADIUS = 1,
    parameter int MAX_WIDTH = 2048
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [swmf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [swmf_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [swmf_pkg::PIX_W-1:0]     s_pixel_ch0,
    input  logic [swmf_pkg::PIX_W-1:0]     s_pixel_ch1,
    input  logic [swmf_pkg::PIX_W-1:0]     s_pixel_ch2,
    input  logic                           s_frame_start,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [swmf_pkg::ROW_W-1:0]     m_out_row,
    output logic [swmf_pkg::COL_W-1:0]     m_out_column,
    output logic [swmf_pkg::PIX_W-1:0]     m_median_ch0,
    output logic [swmf_pkg::PIX_W-1:0]     m_median_ch1,
    output logic [swmf_pkg::PIX_W-1:0]     m_median_ch2,
    output logic                           m_frame_done
);
    import swmf_pkg::*;

    localparam int SIDE = 2 * WINDOW_RADIUS + 1;
    localparam int TAPS = SIDE * SIDE;
    localparam int LINES = 2 * WINDOW_RADIUS;
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int LW = $clog2(LINES);
    localparam int WW = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;

    logic [CFG_W-1:0] width_reg, height_reg;
    logic [1:0]       chan_reg;

    logic [CW-1:0]    col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [LW-1:0]    rmod_reg, rmod_next;

    logic [WW-1:0]    w_eff;
    logic [ROW_W-1:0] h_eff;
    logic [CW-1:0]    c0;
    logic [ROW_W-1:0] r0;
    logic [LW-1:0]    rm0;
    logic             emit0;
    meta_t            meta0;
    logic [WORD_W-1:0] pix0;
    logic             accept;

    logic              v1_reg, emit1_reg;
    logic [WORD_W-1:0] pix1_reg;
    logic [LW-1:0]     rm1_reg;
    meta_t             meta1_reg;
    logic [WORD_W-1:0] ram_q [LINES];
    logic [WORD_W-1:0] line_sel [LINES];

    logic [WORD_W-1:0] win_reg [SIDE][SIDE];
    logic              v2_reg;
    meta_t             meta2_reg;

    logic [TAPS-1:0]   vs_reg;
    meta_t             ms_reg [TAPS];
    logic              mv_reg;

    logic [TAPS-1:0]   ens;
    logic              en_out, en2, en1;

    logic [PIX_W-1:0]  lane_in [CHANNELS][TAPS];
    logic [PIX_W-1:0]  lane_med [CHANNELS];

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg <= RESET_WIDTH;
            height_reg <= RESET_HEIGHT;
            chan_reg <= RESET_CHANNELS;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_IMAGE_WIDTH: width_reg <= cfg_data;
                REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                REG_CHANNEL_COUNT: chan_reg <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // ready chain
    assign en_out = !mv_reg || m_ready;
    always_comb begin
        ens[TAPS-1] = !vs_reg[TAPS-1] || en_out;
        for (int i = TAPS - 2; i >= 0; i--) ens[i] = !vs_reg[i] || ens[i+1];
    end
    assign en2 = !v2_reg || ens[0];
    assign en1 = !v1_reg || en2;
    assign s_ready = en1;
    assign accept = s_valid && en1;

    // position counters
    always_comb begin
        logic [WW-1:0]    c1;
        logic [ROW_W:0]   r1;
        logic [15:0]      col16;
        w_eff = WW'(width_reg);
        if (w_eff == '0) w_eff = WW'(1);
        if (w_eff > WW'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
        h_eff = (height_reg == '0) ? ROW_W'(1) : height_reg;

        c0 = s_frame_start ? '0 : col_reg;
        r0 = s_frame_start ? '0 : row_reg;
        rm0 = s_frame_start ? '0 : rmod_reg;
        if (WW'(c0) >= w_eff) c0 = '0;
        if (r0 >= h_eff) begin
            r0 = '0;
            rm0 = '0;
        end

        c1 = WW'(c0) + WW'(1);
        col_next = c1[CW-1:0];
        row_next = r0;
        rmod_next = rm0;
        r1 = {1'b0, r0} + (ROW_W+1)'(1);
        if (c1 >= w_eff) begin
            col_next = '0;
            if (r1 >= {1'b0, h_eff}) begin
                row_next = '0;
                rmod_next = '0;
            end else begin
                row_next = r1[ROW_W-1:0];
                rmod_next = (rm0 == LW'(LINES - 1)) ? '0 : rm0 + LW'(1);
            end
        end

        emit0 = (r0 >= ROW_W'(LINES)) && (WW'(c0) >= WW'(LINES));
        col16 = 16'(c0) - 16'(WINDOW_RADIUS);
        meta0.row = r0 - ROW_W'(WINDOW_RADIUS);
        meta0.column = col16[COL_W-1:0];
        meta0.done = (r0 == h_eff - ROW_W'(1)) && (WW'(c0) == w_eff - WW'(1));
    end

    assign pix0 = {s_pixel_ch2, s_pixel_ch1, s_pixel_ch0};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
            rmod_reg <= '0;
        end else if (accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
            rmod_reg <= rmod_next;
        end
    end

    // line buffers
    for (genvar p = 0; p < LINES; p++) begin : g_line
        swmf_ram #(
            .WIDTH(WORD_W),
            .DEPTH(MAX_WIDTH)
        ) u_ram (
            .aclk (aclk),
            .en   (en1),
            .we   (accept && (rm0 == LW'(p))),
            .addr (c0),
            .wdata(pix0),
            .rdata(ram_q[p])
        );
    end

    // stage 1
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en1) begin
            v1_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pix1_reg <= pix0;
            rm1_reg <= rm0;
            emit1_reg <= emit0;
            meta1_reg <= meta0;
        end
    end

    always_comb begin
        logic [LW:0] sum;
        for (int k = 0; k < LINES; k++) begin
            sum = (LW+1)'(rm1_reg) + (LW+1)'(k);
            if (sum >= (LW+1)'(LINES)) sum = sum - (LW+1)'(LINES);
            line_sel[k] = ram_q[sum[LW-1:0]];
        end
    end

    // window
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
            for (int k = 0; k < SIDE; k++) begin
                for (int j = 0; j < SIDE; j++) win_reg[k][j] <= '0;
            end
        end else if (en2) begin
            v2_reg <= v1_reg && emit1_reg;
            if (v1_reg) begin
                for (int k = 0; k < SIDE; k++) begin
                    for (int j = 0; j < SIDE - 1; j++) win_reg[k][j] <= win_reg[k][j+1];
                    win_reg[k][SIDE-1] <= (k < LINES) ? line_sel[k] : pix1_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en2) begin
            meta2_reg <= meta1_reg;
        end
    end

    // sort pipeline control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vs_reg <= '0;
            mv_reg <= 1'b0;
        end else begin
            if (ens[0]) vs_reg[0] <= v2_reg;
            for (int i = 1; i < TAPS; i++) begin
                if (ens[i]) vs_reg[i] <= vs_reg[i-1];
            end
            if (en_out) mv_reg <= vs_reg[TAPS-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (ens[0]) ms_reg[0] <= meta2_reg;
        for (int i = 1; i < TAPS; i++) begin
            if (ens[i]) ms_reg[i] <= ms_reg[i-1];
        end
    end

    // lanes
    for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_lane
        for (genvar n = 0; n < TAPS; n++) begin : g_tap
            assign lane_in[ch][n] = win_reg[n / SIDE][n % SIDE][PIX_W*ch +: PIX_W];
        end

        swmf_lane #(
            .TAPS(TAPS)
        ) u_lane (
            .aclk    (aclk),
            .stage_en(ens),
            .win     (lane_in[ch]),
            .median  (lane_med[ch])
        );
    end

    swmf_merge u_merge (
        .aclk         (aclk),
        .load         (en_out),
        .channel_count(chan_reg),
        .meta         (ms_reg[TAPS-1]),
        .lane_median  (lane_med),
        .out_row      (m_out_row),
        .out_column   (m_out_column),
        .median_ch0   (m_median_ch0),
        .median_ch1   (m_median_ch1),
        .median_ch2   (m_median_ch2),
        .frame_done   (m_frame_done)
    );

    assign m_valid = mv_reg;

    a_coord_interior: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_out_row >= ROW_W'(WINDOW_RADIUS)) &&
                    (m_out_column >= COL_W'(WINDOW_RADIUS)))
        else $error("result centre on the border");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !v1_reg |-> s_ready)
        else $error("input stalled with empty first stage");

    a_column_range: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(col_reg) < MAX_WIDTH)
        else $error("column counter past line buffer depth");

    a_window_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && en2) |=> $past(pix1_reg) == win_reg[SIDE-1][SIDE-1])
        else $error("window did not take the new word");

endmodule

// ----- bench/swmf_checker.sv -----
// Checker of the sliding window median filter: predicts results from accepted words.
module swmf_checker
    import swmf_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [PIX_W-1:0]   s_pixel_ch0,
    input  logic [PIX_W-1:0]   s_pixel_ch1,
    input  logic [PIX_W-1:0]   s_pixel_ch2,
    input  logic               s_frame_start,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [ROW_W-1:0]   m_out_row,
    input  logic [COL_W-1:0]   m_out_column,
    input  logic [PIX_W-1:0]   m_median_ch0,
    input  logic [PIX_W-1:0]   m_median_ch1,
    input  logic [PIX_W-1:0]   m_median_ch2,
    input  logic               m_frame_done,
    output int                 fail_count,
    output int                 pending,
    output int                 medians_seen
);

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] column;
        logic [PIX_W-1:0] med0;
        logic [PIX_W-1:0] med1;
        logic [PIX_W-1:0] med2;
        logic             done;
    } median_t;

    median_t         median_queue[$];
    logic [11:0]     width_reg;
    logic [11:0]     height_reg;
    logic [1:0]      chans_reg;
    logic [WORD_W-1:0] lines[2][2048];
    logic [WORD_W-1:0] win[3][3];
    int unsigned     col_pos;
    int unsigned     row_pos;

    assign pending = median_queue.size();

    function automatic logic [PIX_W-1:0] window_median(int ch);
        logic [PIX_W-1:0] v[9];
        logic [PIX_W-1:0] t;
        for (int k = 0; k < 3; k++)
            for (int j = 0; j < 3; j++)
                v[k*3+j] = win[k][j][ch*PIX_W +: PIX_W];
        for (int i = 0; i < 9; i++)
            for (int j = 0; j < 8 - i; j++)
                if (v[j] > v[j+1]) begin
                    t = v[j];
                    v[j] = v[j+1];
                    v[j+1] = t;
                end
        return v[4];
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    task automatic predict_median(logic [WORD_W-1:0] px, logic fs);
        int unsigned w, h, r, c;
        median_t m;
        w = (width_reg == 0) ? 1 : (width_reg > 2048 ? 2048 : width_reg);
        h = (height_reg == 0) ? 1 : height_reg;
        if (fs) begin
            col_pos = 0;
            row_pos = 0;
        end
        if (col_pos >= w) col_pos = 0;
        if (row_pos >= h) row_pos = 0;
        r = row_pos;
        c = col_pos;
        for (int k = 0; k < 3; k++) begin
            win[k][0] = win[k][1];
            win[k][1] = win[k][2];
            win[k][2] = (k < 2) ? lines[(r + k) % 2][c] : px;
        end
        lines[r % 2][c] = px;
        if (r >= 2 && c >= 2) begin
            m.row = ROW_W'(r - 1);
            m.column = COL_W'(c - 1);
            m.med0 = (chans_reg > 0) ? window_median(0) : '0;
            m.med1 = (chans_reg > 1) ? window_median(1) : '0;
            m.med2 = (chans_reg > 2) ? window_median(2) : '0;
            m.done = (r == h - 1) && (c == w - 1);
            median_queue.push_back(m);
        end
        col_pos = c + 1;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos = r + 1;
            if (row_pos >= h) row_pos = 0;
        end
    endtask

    initial begin
        fail_count = 0;
        medians_seen = 0;
    end

    always @(posedge aclk) begin
        median_t e;
        if (!aresetn) begin
            width_reg <= RESET_WIDTH;
            height_reg <= RESET_HEIGHT;
            chans_reg <= RESET_CHANNELS;
            col_pos = 0;
            row_pos = 0;
            for (int k = 0; k < 3; k++)
                for (int j = 0; j < 3; j++)
                    win[k][j] = '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_IMAGE_WIDTH: width_reg <= cfg_data;
                    REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                    REG_CHANNEL_COUNT: chans_reg <= cfg_data[1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                predict_median({s_pixel_ch2, s_pixel_ch1, s_pixel_ch0}, s_frame_start);
            if (m_valid && m_ready) begin
                medians_seen++;
                if (median_queue.size() == 0) begin
                    report("unexpected word", 32'(m_out_row), 32'(0));
                end else begin
                    e = median_queue.pop_front();
                    if (m_out_row !== e.row)
                        report("row", 32'(m_out_row), 32'(e.row));
                    if (m_out_column !== e.column)
                        report("column", 32'(m_out_column), 32'(e.column));
                    if (m_median_ch0 !== e.med0)
                        report("ch0", 32'(m_median_ch0), 32'(e.med0));
                    if (m_median_ch1 !== e.med1)
                        report("ch1", 32'(m_median_ch1), 32'(e.med1));
                    if (m_median_ch2 !== e.med2)
                        report("ch2", 32'(m_median_ch2), 32'(e.med2));
                    if (m_frame_done !== e.done)
                        report("frame_done", 32'(m_frame_done), 32'(e.done));
                end
            end
        end
    end

endmodule

// ----- bench/tb_top.sv -----
// Testbench top of the sliding window median filter: stimulus and verdict.
module tb_top;
    import swmf_pkg::*;

    localparam int WATCHDOG = 20000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = REG_IMAGE_WIDTH;
    logic [CFG_W-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [PIX_W-1:0] s_pixel_ch0 = '0;
    logic [PIX_W-1:0] s_pixel_ch1 = '0;
    logic [PIX_W-1:0] s_pixel_ch2 = '0;
    logic s_frame_start = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [ROW_W-1:0] m_out_row;
    logic [COL_W-1:0] m_out_column;
    logic [PIX_W-1:0] m_median_ch0;
    logic [PIX_W-1:0] m_median_ch1;
    logic [PIX_W-1:0] m_median_ch2;
    logic m_frame_done;
    int fail_count;
    int pending;
    int medians_seen;
    int idle_cycles = 0;
    int words_sent = 0;
    int frames_sent = 0;
    bit sink_calm = 1'b0;
    bit sink_hold = 1'b0;

    always #6 aclk = ~aclk;

    sliding_window_median_filter u_dut (.*);

    swmf_checker u_checker (.*);

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("[sliding_window_median_filter] ERROR");
            $finish;
        end
    end

    initial begin
        int stall;
        forever begin
            @(negedge aclk);
            if (sink_hold) begin
                m_ready <= 1'b0;
                repeat (300) @(negedge aclk);
                sink_hold = 1'b0;
            end else if (!sink_calm && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                stall = $urandom_range(1, 6);
                repeat (stall - 1) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_pixel(logic [7:0] p0, logic [7:0] p1, logic [7:0] p2,
                              logic fs, bit gaps);
        if (gaps && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_pixel_ch0 <= p0;
        s_pixel_ch1 <= p1;
        s_pixel_ch2 <= p2;
        s_frame_start <= fs;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        words_sent++;
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    task automatic send_frame(int w, int h, int mode, bit gaps);
        logic [7:0] v;
        for (int r = 0; r < h; r++)
            for (int c = 0; c < w; c++) begin
                case (mode)
                    0: v = 8'd0;
                    1: v = 8'd255;
                    2: v = ((r + c) % 2) ? 8'd255 : 8'd0;
                    default: v = 8'($urandom);
                endcase
                send_pixel(v, (mode > 2) ? 8'($urandom) : ~v,
                           (mode > 2) ? 8'($urandom) : v ^ 8'h5a,
                           (r == 0 && c == 0), gaps);
            end
        frames_sent++;
    endtask

    initial begin
        int w, h;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        write_reg(REG_IMAGE_WIDTH, 12'd3);
        write_reg(REG_IMAGE_HEIGHT, 12'd3);
        write_reg(REG_CHANNEL_COUNT, 12'd3);
        send_frame(3, 3, 0, 0);
        send_frame(3, 3, 1, 0);
        drain_results();
        write_reg(REG_IMAGE_WIDTH, 12'd2);
        write_reg(REG_IMAGE_WIDTH, 12'd3);
        send_frame(3, 2, 2, 0);
        drain_results();
        write_reg(REG_IMAGE_WIDTH, 12'd2);
        send_frame(2, 3, 3, 0);
        drain_results();

        for (int phase = 0; phase < 8; phase++) begin
            w = (phase == 7) ? 80 : $urandom_range(3, 12);
            h = (phase == 7) ? 3 : $urandom_range(3, 10);
            if (phase == 6) h = 4095;
            write_reg(REG_IMAGE_WIDTH, CFG_W'(w));
            write_reg(REG_IMAGE_HEIGHT, CFG_W'(h));
            write_reg(REG_CHANNEL_COUNT, CFG_W'((phase % 3) + 1));
            if (phase == 2) sink_hold = 1'b1;
            if (phase == 7) sink_calm = 1'b1;
            if (phase == 6) begin
                send_frame(w, 4, 3, 1);
            end else if (phase == 7) begin
                send_frame(w, 3, 3, 0);
            end else begin
                for (int f = 0; f < 2; f++) send_frame(w, h, 3, 1);
                for (int k = 0; k < 10; k++)
                    send_pixel(8'($urandom), 8'($urandom), 8'($urandom),
                               $urandom_range(0, 7) == 0, 1);
            end
            drain_results();
        end

        $display("sent %0d words in %0d frames, checked %0d medians, widths 2..80",
                 words_sent, frames_sent, medians_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("[sliding_window_median_filter] OK");
        end else begin
            $display("[sliding_window_median_filter] ERROR");
        end
        $finish;
    end

endmodule

// ----- sliding_window_median_filter.f -----
hw/rtl/swmf_pkg.sv
hw/rtl/swmf_ram.sv
hw/rtl/swmf_lane.sv
hw/rtl/swmf_merge.sv
hw/rtl/sliding_window_median_filter.sv
bench/swmf_checker.sv
bench/tb_top.sv
